FILE: hdl/scpd_pkg.sv
// ----------------------------------------------------------------------------
// scpd_pkg
// Shared types and constants for the segment closest point pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package scpd_pkg;

    localparam int COORD_W   = 32;
    localparam int THRESH_W  = 16;
    localparam int INDEX_W   = 3;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int LEN2_W    = SQ_W;
    localparam int DOT_W     = SQ_W + 2;
    localparam int DIV_QBITS = DIFF_W;
    localparam int NUM_W     = DIFF_W + LEN2_W;
    localparam int DEN_W     = LEN2_W;
    localparam int RAD_W     = SQ_W + 2;
    localparam int SQRT_BITS = RAD_W / 2;
    localparam int GAP_W     = 33;
    localparam int FRONT_LAT = 5;
    localparam int BACK_LAT  = 4;
    localparam int TOTAL_LAT = FRONT_LAT + DIV_QBITS + BACK_LAT + SQRT_BITS + 1;

    typedef enum logic [INDEX_W-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5,
        REG_THRESH  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic degen;
        logic lo;
        logic hi;
    } flags_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] pt;
        flags_t                  flags;
    } div_side_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] nr;
        logic                    degen;
    } sqrt_side_t;

endpackage

`default_nettype wire

FILE: hdl/scpd_div.sv
// ----------------------------------------------------------------------------
// scpd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module scpd_div
(
    input  wire logic                          clk,
    input  wire logic [scpd_pkg::NUM_W-1:0]    num,
    input  wire logic [scpd_pkg::DEN_W-1:0]    den,
    output logic      [scpd_pkg::DIV_QBITS-1:0] quot
);

    localparam int QB = scpd_pkg::DIV_QBITS;
    localparam int DW = scpd_pkg::DEN_W;
    localparam int NW = scpd_pkg::NUM_W;

    logic [DW-1:0] rem_reg  [QB];
    logic [QB-1:0] quot_reg [QB];
    logic [QB-1:0] low_reg  [QB-1];
    logic [DW-1:0] den_reg  [QB-1];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QB-1:0] low_in;
        logic [QB-1:0] q_in;
        logic [DW-1:0] d_in;
        logic [DW:0]   trial;
        logic [DW+1:0] diff;

        if (k == 0) begin : g_first
            assign rem_in = num[NW-1:QB];
            assign low_in = num[QB-1:0];
            assign q_in   = '0;
            assign d_in   = den;
        end
        else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign q_in   = quot_reg[k-1];
            assign d_in   = den_reg[k-1];
        end

        assign trial = {rem_in, low_in[QB-1]};
        assign diff  = {1'b0, trial} - {2'b00, d_in};

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= diff[DW+1] ? trial[DW-1:0] : diff[DW-1:0];
            quot_reg[k] <= {q_in[QB-2:0], ~diff[DW+1]};
        end

        if (k < QB - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                low_reg[k] <= {low_in[QB-2:0], 1'b0};
                den_reg[k] <= d_in;
            end
        end
    end

    assign quot = quot_reg[QB-1];

endmodule

`default_nettype wire

FILE: hdl/scpd_sqrt.sv
// ----------------------------------------------------------------------------
// scpd_sqrt
// Pipelined digit-by-digit floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module scpd_sqrt
(
    input  wire logic                           clk,
    input  wire logic [scpd_pkg::RAD_W-1:0]     rad,
    output logic      [scpd_pkg::SQRT_BITS-1:0] root
);

    localparam int SB = scpd_pkg::SQRT_BITS;
    localparam int RW = scpd_pkg::RAD_W;
    localparam int MW = SB + 2;

    logic [MW-1:0] rem_reg  [SB];
    logic [SB-1:0] root_reg [SB];
    logic [RW-1:0] rad_reg  [SB-1];

    for (genvar k = 0; k < SB; k++) begin : g_stage
        logic [MW-1:0] rem_in;
        logic [SB-1:0] root_in;
        logic [RW-1:0] rad_in;
        logic [MW+1:0] trial;
        logic [MW-1:0] test;
        logic [MW+2:0] diff;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        assign trial = {rem_in, rad_in[RW-1:RW-2]};
        assign test  = {root_in, 2'b01};
        assign diff  = {1'b0, trial} - {3'b000, test};

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= diff[MW+2] ? trial[MW-1:0] : diff[MW-1:0];
            root_reg[k] <= {root_in[SB-2:0], ~diff[MW+2]};
        end

        if (k < SB - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                rad_reg[k] <= {rad_in[RW-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SB-1];

endmodule

`default_nettype wire

FILE: hdl/segment_closest_point_distance.sv
// ----------------------------------------------------------------------------
// segment_closest_point_distance
// Projects a query point onto a configured 3D segment, clamps it to the
// segment's ends, and returns the closest point and the floor distance.
//
//   channel   signals                                   handshake
//   query     point_x, point_y, point_z                 start, busy
//   result    valid_res, near_x, near_y, near_z, gap    done
//   config    wr_index, wr_data                         wr_en
//
// One query enters every cycle; busy stays low. Each result passes through
// the 33 divider stages and 34 square root stages. The result strobe
// lasts one cycle and cannot be held off.
// Reset clears the configuration and all stage valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_closest_point_distance
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [scpd_pkg::COORD_W-1:0]  point_x,
    input  wire logic signed [scpd_pkg::COORD_W-1:0]  point_y,
    input  wire logic signed [scpd_pkg::COORD_W-1:0]  point_z,
    output logic                                      done,
    output logic                                      valid_res,
    output logic signed      [scpd_pkg::COORD_W-1:0]  near_x,
    output logic signed      [scpd_pkg::COORD_W-1:0]  near_y,
    output logic signed      [scpd_pkg::COORD_W-1:0]  near_z,
    output logic             [scpd_pkg::GAP_W-1:0]    gap,
    input  wire logic                                 wr_en,
    input  wire logic        [scpd_pkg::INDEX_W-1:0]  wr_index,
    input  wire logic        [scpd_pkg::COORD_W-1:0]  wr_data
);

    localparam int CW = scpd_pkg::COORD_W;
    localparam int DF = scpd_pkg::DIFF_W;
    localparam int SQ = scpd_pkg::SQ_W;
    localparam int LW = scpd_pkg::LEN2_W;
    localparam int OW = scpd_pkg::DOT_W;
    localparam int NW = scpd_pkg::NUM_W;
    localparam int RW = scpd_pkg::RAD_W;
    localparam int QB = scpd_pkg::DIV_QBITS;
    localparam int SB = scpd_pkg::SQRT_BITS;
    localparam int GW = scpd_pkg::GAP_W;

    // configuration
    logic [2:0][CW-1:0]                s_reg;
    logic [2:0][CW-1:0]                e_reg;
    logic [scpd_pkg::THRESH_W-1:0]     thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg      <= '0;
            e_reg      <= '0;
            thresh_reg <= '0;
        end
        else if (wr_en)
        begin
            case (scpd_pkg::reg_idx_t'(wr_index))
                scpd_pkg::REG_START_X: s_reg[0]   <= wr_data;
                scpd_pkg::REG_START_Y: s_reg[1]   <= wr_data;
                scpd_pkg::REG_START_Z: s_reg[2]   <= wr_data;
                scpd_pkg::REG_END_X:   e_reg[0]   <= wr_data;
                scpd_pkg::REG_END_Y:   e_reg[1]   <= wr_data;
                scpd_pkg::REG_END_Z:   e_reg[2]   <= wr_data;
                scpd_pkg::REG_THRESH:  thresh_reg <= wr_data[scpd_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [DF-1:0] lcfg [3];
    logic        [DF-1:0] lmag [3];
    logic [2:0][CW-1:0]   pin;

    assign pin = {point_z, point_y, point_x};

    for (genvar c = 0; c < 3; c++) begin : g_len
        assign lcfg[c] = $signed({e_reg[c][CW-1], e_reg[c]})
                       - $signed({s_reg[c][CW-1], s_reg[c]});
        assign lmag[c] = lcfg[c][DF-1] ? DF'(-lcfg[c]) : DF'(lcfg[c]);
    end

    assign busy = 1'b0;

    // front stages: offsets, products, sums, classification, numerators
    logic                  vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;
    logic [2:0][CW-1:0]    p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [DF-1:0]  v1_reg  [3];
    logic        [SQ-2:0]  sq2_reg [3];
    logic signed [SQ-1:0]  lv2_reg [3];
    logic        [LW-1:0]  len2_3_reg, len2_4_reg, den5_reg;
    logic signed [OW-1:0]  dot3_reg;
    scpd_pkg::flags_t      flags4_reg, flags5_reg;
    logic        [SQ-1:0]  pl4_reg [3];
    logic        [SQ-1:0]  ph4_reg [3];
    logic        [NW-1:0]  num5_reg [3];

    logic signed [SQ-1:0]  sq_full  [3];
    logic signed [SQ-1:0]  lv_next  [3];
    logic        [LW-1:0]  len2_next;
    logic signed [OW-1:0]  dot_next;
    scpd_pkg::flags_t      flags_next;

    for (genvar c = 0; c < 3; c++) begin : g_prod
        assign sq_full[c] = lcfg[c] * lcfg[c];
        assign lv_next[c] = lcfg[c] * v1_reg[c];
    end

    assign len2_next = LW'(sq2_reg[0]) + LW'(sq2_reg[1]) + LW'(sq2_reg[2]);
    assign dot_next  = OW'(lv2_reg[0]) + OW'(lv2_reg[1]) + OW'(lv2_reg[2]);

    always_comb
    begin
        flags_next.degen = len2_3_reg <= LW'(thresh_reg);
        flags_next.lo    = dot3_reg[OW-1] | ~(|dot3_reg);
        flags_next.hi    = ~flags_next.lo
                         & (dot3_reg[OW-2:0] >= {1'b0, len2_3_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start & ~busy;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg     <= pin;
        p2_reg     <= p1_reg;
        p3_reg     <= p2_reg;
        p4_reg     <= p3_reg;
        p5_reg     <= p4_reg;
        len2_3_reg <= len2_next;
        dot3_reg   <= dot_next;
        len2_4_reg <= len2_3_reg;
        flags4_reg <= flags_next;
        den5_reg   <= len2_4_reg;
        flags5_reg <= flags4_reg;
        for (int c = 0; c < 3; c++)
        begin
            v1_reg[c]   <= $signed({pin[c][CW-1], pin[c]})
                         - $signed({s_reg[c][CW-1], s_reg[c]});
            sq2_reg[c]  <= sq_full[c][SQ-2:0];
            lv2_reg[c]  <= lv_next[c];
            pl4_reg[c]  <= lmag[c] * dot3_reg[DF-1:0];
            ph4_reg[c]  <= lmag[c] * dot3_reg[2*DF-1:DF];
            num5_reg[c] <= NW'(pl4_reg[c]) + {ph4_reg[c], {DF{1'b0}}};
        end
    end

    // dividers with aligned side data
    logic [QB-1:0] quot [3];

    for (genvar c = 0; c < 3; c++) begin : g_div
        scpd_div u_div
        (
            .clk  (clk),
            .num  (num5_reg[c]),
            .den  (den5_reg),
            .quot (quot[c])
        );
    end

    logic                   vldd_reg  [QB];
    scpd_pkg::div_side_t    sided_reg [QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QB; k++)
            begin
                vldd_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vldd_reg[0] <= vld5_reg;
            for (int k = 1; k < QB; k++)
            begin
                vldd_reg[k] <= vldd_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sided_reg[0].pt    <= p5_reg;
        sided_reg[0].flags <= flags5_reg;
        for (int k = 1; k < QB; k++)
        begin
            sided_reg[k] <= sided_reg[k-1];
        end
    end

    // back stages: clamp and place, offsets, squares, sum
    scpd_pkg::div_side_t   side_out;
    logic [2:0][CW-1:0]    nr_next;
    logic                  vld6_reg, vld7_reg, vld8_reg, vld9_reg;
    logic [2:0][CW-1:0]    p6_reg, nr6_reg, nr7_reg, nr8_reg, nr9_reg;
    logic                  degen6_reg, degen7_reg, degen8_reg, degen9_reg;
    logic [DF-1:0]         mag7_reg [3];
    logic [SQ-1:0]         sq8_reg  [3];
    logic [RW-1:0]         dist9_reg;
    logic [DF-1:0]         diff_next [3];

    assign side_out = sided_reg[QB-1];

    for (genvar c = 0; c < 3; c++) begin : g_near
        logic [CW+1:0] sum_pos;
        logic [CW+1:0] sum_neg;

        assign sum_pos = {{2{s_reg[c][CW-1]}}, s_reg[c]} + {1'b0, quot[c]};
        assign sum_neg = {{2{s_reg[c][CW-1]}}, s_reg[c]} - {1'b0, quot[c]};

        always_comb
        begin
            if (side_out.flags.lo)
            begin
                nr_next[c] = s_reg[c];
            end
            else if (side_out.flags.hi)
            begin
                nr_next[c] = e_reg[c];
            end
            else if (lcfg[c][DF-1])
            begin
                nr_next[c] = sum_neg[CW-1:0];
            end
            else
            begin
                nr_next[c] = sum_pos[CW-1:0];
            end
        end

        assign diff_next[c] = {p6_reg[c][CW-1], p6_reg[c]} - {nr6_reg[c][CW-1], nr6_reg[c]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld6_reg <= 1'b0;
            vld7_reg <= 1'b0;
            vld8_reg <= 1'b0;
            vld9_reg <= 1'b0;
        end
        else
        begin
            vld6_reg <= vldd_reg[QB-1];
            vld7_reg <= vld6_reg;
            vld8_reg <= vld7_reg;
            vld9_reg <= vld8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p6_reg     <= side_out.pt;
        nr6_reg    <= nr_next;
        degen6_reg <= side_out.flags.degen;
        nr7_reg    <= nr6_reg;
        degen7_reg <= degen6_reg;
        nr8_reg    <= nr7_reg;
        degen8_reg <= degen7_reg;
        nr9_reg    <= nr8_reg;
        degen9_reg <= degen8_reg;
        for (int c = 0; c < 3; c++)
        begin
            mag7_reg[c] <= diff_next[c][DF-1] ? DF'(-diff_next[c]) : diff_next[c];
            sq8_reg[c]  <= mag7_reg[c] * mag7_reg[c];
        end
        dist9_reg <= RW'(sq8_reg[0]) + RW'(sq8_reg[1]) + RW'(sq8_reg[2]);
    end

    // square root with aligned side data
    logic [SB-1:0] root;

    scpd_sqrt u_sqrt
    (
        .clk  (clk),
        .rad  (dist9_reg),
        .root (root)
    );

    logic                   vldq_reg  [SB];
    scpd_pkg::sqrt_side_t   sideq_reg [SB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SB; k++)
            begin
                vldq_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vldq_reg[0] <= vld9_reg;
            for (int k = 1; k < SB; k++)
            begin
                vldq_reg[k] <= vldq_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sideq_reg[0].nr    <= nr9_reg;
        sideq_reg[0].degen <= degen9_reg;
        for (int k = 1; k < SB; k++)
        begin
            sideq_reg[k] <= sideq_reg[k-1];
        end
    end

    // result word
    logic                 done_reg;
    logic                 valid_res_reg;
    logic [2:0][CW-1:0]   near_reg;
    logic [GW-1:0]        gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vldq_reg[SB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sideq_reg[SB-1].degen)
        begin
            valid_res_reg <= 1'b0;
            near_reg      <= '0;
            gap_reg       <= '1;
        end
        else
        begin
            valid_res_reg <= 1'b1;
            near_reg      <= sideq_reg[SB-1].nr;
            gap_reg       <= root[GW-1:0];
        end
    end

    assign done      = done_reg;
    assign valid_res = valid_res_reg;
    assign near_x    = near_reg[0];
    assign near_y    = near_reg[1];
    assign near_z    = near_reg[2];
    assign gap       = gap_reg;

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, scpd_pkg::TOTAL_LAT))
        else $error("result word without matching query");

    a_near_x_on_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (done && valid_res) |->
            ((near_x >= $signed(s_reg[0]) && near_x <= $signed(e_reg[0])) ||
             (near_x <= $signed(s_reg[0]) && near_x >= $signed(e_reg[0]))))
        else $error("near_x off segment");

    a_near_y_on_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (done && valid_res) |->
            ((near_y >= $signed(s_reg[1]) && near_y <= $signed(e_reg[1])) ||
             (near_y <= $signed(s_reg[1]) && near_y >= $signed(e_reg[1]))))
        else $error("near_y off segment");
`endif

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segment_closest_point_distance: directed table then
// random query points under several segments, checked against a predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W   = scpd_pkg::COORD_W;
    localparam int GAP_W     = scpd_pkg::GAP_W;
    localparam int INDEX_W   = scpd_pkg::INDEX_W;
    localparam int THRESH_W  = scpd_pkg::THRESH_W;
    localparam int TOTAL_LAT = scpd_pkg::TOTAL_LAT;

    localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int WATCH_LIMIT = 4000;

    typedef struct {
        logic                      ok;
        logic signed [COORD_W-1:0] nx, ny, nz;
        logic [GAP_W-1:0]          dist_val;
    } near_word_t;

    typedef struct {
        int                        seg;
        logic signed [COORD_W-1:0] x, y, z;
        bit                        typed;
        near_word_t                want;
    } query_row_t;

    logic clk, rst_n, start, busy, done, valid_res, wr_en;
    logic signed [COORD_W-1:0] point_x, point_y, point_z, near_x, near_y, near_z;
    logic [GAP_W-1:0] gap;
    logic [INDEX_W-1:0] wr_index;
    logic [COORD_W-1:0] wr_data;

    logic signed [COORD_W-1:0] seg_reg [6];
    logic [THRESH_W-1:0] seg_thresh;
    logic drv_typed;
    near_word_t drv_want;
    near_word_t pending_near [$];
    int error_count;
    int idle_cycles;

    segment_closest_point_distance u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .done(done), .valid_res(valid_res),
        .near_x(near_x), .near_y(near_y), .near_z(near_z), .gap(gap),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic near_word_t project_point(input logic signed [COORD_W-1:0] px,
                                                 input logic signed [COORD_W-1:0] py,
                                                 input logic signed [COORD_W-1:0] pz);
        logic signed [127:0] s [3];
        logic signed [127:0] l [3];
        logic signed [127:0] p [3];
        logic signed [127:0] nr [3];
        logic signed [127:0] len2, dot, mag, quo, d;
        logic [127:0] dist2, cand, root;
        near_word_t r;
        len2 = 0;
        dot = 0;
        dist2 = 0;
        root = 0;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        for (int c = 0; c < 3; c++)
        begin
            s[c] = seg_reg[c];
            l[c] = seg_reg[3 + c];
            l[c] = l[c] - s[c];
            len2 = len2 + l[c] * l[c];
            dot = dot + l[c] * (p[c] - s[c]);
        end
        if (len2 <= $signed({112'd0, seg_thresh}))
        begin
            r.ok = 1'b0;
            r.nx = '0;
            r.ny = '0;
            r.nz = '0;
            r.dist_val = '1;
            return r;
        end
        for (int c = 0; c < 3; c++)
        begin
            if (dot <= 0)
                nr[c] = s[c];
            else if (dot >= len2)
                nr[c] = s[c] + l[c];
            else
            begin
                mag = (l[c] < 0) ? -l[c] : l[c];
                quo = (mag * dot) / len2;
                nr[c] = (l[c] < 0) ? s[c] - quo : s[c] + quo;
            end
            d = p[c] - nr[c];
            dist2 = dist2 + $unsigned(d * d);
        end
        for (int b = 33; b >= 0; b--)
        begin
            cand = root | (128'd1 << b);
            if (cand * cand <= dist2)
                root = cand;
        end
        r.ok = 1'b1;
        r.nx = nr[0][COORD_W-1:0];
        r.ny = nr[1][COORD_W-1:0];
        r.nz = nr[2][COORD_W-1:0];
        r.dist_val = root[GAP_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        near_word_t w;
        if (rst_n)
        begin
            if (wr_en)
            begin
                case (wr_index)
                    scpd_pkg::REG_START_X, scpd_pkg::REG_START_Y, scpd_pkg::REG_START_Z,
                    scpd_pkg::REG_END_X, scpd_pkg::REG_END_Y,
                    scpd_pkg::REG_END_Z: seg_reg[wr_index] <= wr_data;
                    scpd_pkg::REG_THRESH: seg_thresh <= wr_data[THRESH_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                pending_near.push_back(drv_typed ? drv_want
                                                 : project_point(point_x, point_y, point_z));
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done)
            begin
                if (pending_near.size() == 0)
                    report_mismatch("unexpected word", 64'd0, 64'd0);
                else
                begin
                    w = pending_near.pop_front();
                    if (valid_res !== w.ok) report_mismatch("valid_res", valid_res, w.ok);
                    if (near_x !== w.nx) report_mismatch("near_x", near_x, w.nx);
                    if (near_y !== w.ny) report_mismatch("near_y", near_y, w.ny);
                    if (near_z !== w.nz) report_mismatch("near_z", near_z, w.nz);
                    if (gap !== w.dist_val) report_mismatch("gap", gap, w.dist_val);
                end
            end
        end
    end

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_cycles >= WATCH_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_point(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                              input logic signed [COORD_W-1:0] z, input int idle_pct,
                              input bit typed, input near_word_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        point_x <= x;
        point_y <= y;
        point_z <= z;
        drv_typed <= typed;
        drv_want <= want;
        forever
        begin
            @(negedge clk);
            if (!busy)
            begin
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_near.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_segment(input logic [COORD_W-1:0] v [7]);
        drain();
        for (int i = 0; i < 7; i++)
        begin
            wr_en <= 1'b1;
            wr_index <= i[INDEX_W-1:0];
            wr_data <= v[i];
            @(posedge clk);
        end
        wr_index <= REG_UNUSED;
        wr_data <= $urandom;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    function automatic logic signed [COORD_W-1:0] near_coord(input logic signed [COORD_W-1:0] a,
                                                             input logic signed [COORD_W-1:0] b);
        logic signed [34:0] t;
        case ($urandom_range(3))
            0: t = a;
            1: t = b;
            default: t = (35'(a) + 35'(b)) / 2;
        endcase
        t = t + $signed(35'($urandom_range(2047))) - 35'sd1024;
        if (t > 35'sh7fffffff) t = 35'sh7fffffff;
        if (t < -35'sh80000000) t = -35'sh80000000;
        return t[COORD_W-1:0];
    endfunction

    task automatic random_phase(input int idle_pct, input int items);
        logic [COORD_W-1:0] v [7];
        logic signed [COORD_W-1:0] base, x, y, z;
        near_word_t none;
        none = '{1'b0, '0, '0, '0, '0};
        for (int k = 0; k < 4; k++)
        begin
            case ($urandom_range(4))
                0:
                begin
                    for (int i = 0; i < 6; i++) v[i] = $urandom;
                    v[6] = $urandom_range(65535);
                end
                1:
                begin
                    for (int i = 0; i < 3; i++) v[i] = 32'h8000_0000;
                    for (int i = 3; i < 6; i++) v[i] = 32'h7fff_ffff;
                    v[6] = 32'd65535;
                end
                2:
                begin
                    base = $urandom;
                    for (int i = 0; i < 6; i++) v[i] = base + $urandom_range(300) - 150;
                    v[6] = $urandom_range(1) ? 32'd65535 : $urandom_range(40000);
                end
                default:
                begin
                    base = $urandom;
                    base = base >>> 8;
                    for (int i = 0; i < 6; i++) v[i] = base + $urandom_range(1 << 22) - (1 << 21);
                    v[6] = $urandom_range(1) ? 32'd0 : $urandom_range(65535);
                end
            endcase
            load_segment(v);
            for (int n = 0; n < items / 4; n++)
            begin
                if ($urandom_range(1))
                begin
                    x = near_coord(v[0], v[3]);
                    y = near_coord(v[1], v[4]);
                    z = near_coord(v[2], v[5]);
                end
                else
                begin
                    x = $urandom;
                    y = $urandom;
                    z = $urandom;
                end
                if (k == 1 && n == items / 8)
                    drain();
                send_point(x, y, z, idle_pct, 1'b0, none);
            end
        end
    endtask

    initial
    begin
        logic [COORD_W-1:0] seg_set [5][7];
        query_row_t rows [$];
        near_word_t degen, none;
        logic [COORD_W-1:0] one_seg [7];
        int cur;
        localparam logic signed [COORD_W-1:0] MAXC = 32'sh7fff_ffff;
        localparam logic signed [COORD_W-1:0] MINC = -32'sh8000_0000;

        rst_n = 1'b0;
        start = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        drv_typed = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        for (int i = 0; i < 6; i++) seg_reg[i] = '0;
        seg_thresh = '0;
        degen = '{1'b0, '0, '0, '0, '1};
        none = '{1'b0, '0, '0, '0, '0};
        drv_want = none;

        seg_set[0] = '{0, 0, 0, 0, 0, 0, 0};
        seg_set[1] = '{MINC, MINC, MINC, MAXC, MAXC, MAXC, 0};
        seg_set[2] = '{0, 0, 0, 255, 0, 0, 65535};
        seg_set[3] = '{0, 0, 0, 256, 0, 0, 65535};
        seg_set[4] = '{32'h0001_0000, 32'hffff_0000, 0, 32'hfffd_0000, 32'h0002_0000,
                       32'h0005_0000, 0};

        rows.push_back('{0, 0, 0, 0, 1'b1, degen});
        rows.push_back('{0, MAXC, MAXC, MAXC, 1'b1, degen});
        rows.push_back('{0, MINC, MINC, MINC, 1'b1, degen});
        rows.push_back('{1, MINC, MINC, MINC, 1'b0, none});
        rows.push_back('{1, MAXC, MAXC, MAXC, 1'b0, none});
        rows.push_back('{1, 0, 0, 0, 1'b0, none});
        rows.push_back('{1, MINC, MAXC, 0, 1'b0, none});
        rows.push_back('{1, MAXC, MINC, MINC, 1'b0, none});
        rows.push_back('{2, 0, 0, 0, 1'b1, degen});
        rows.push_back('{2, MAXC, MINC, MAXC, 1'b1, degen});
        rows.push_back('{3, 128, 0, 0, 1'b0, none});
        rows.push_back('{3, -5, 7, 9, 1'b0, none});
        rows.push_back('{3, 1000, 0, 0, 1'b0, none});
        rows.push_back('{3, 300, -300, 3, 1'b0, none});
        rows.push_back('{4, 32'h0001_0000, 32'hffff_0000, 0, 1'b0, none});
        rows.push_back('{4, 32'hfffd_0000, 32'h0002_0000, 32'h0005_0000, 1'b0, none});
        rows.push_back('{4, 32'hffff_0000, 32'h0000_8000, 32'h0002_8000, 1'b0, none});
        rows.push_back('{4, 32'h0010_0000, 32'hfff0_0000, 32'hfff0_0000, 1'b0, none});
        rows.push_back('{4, 32'hfff0_0000, 32'h0010_0000, 32'h0010_0000, 1'b0, none});
        rows.push_back('{4, MAXC, MINC, MAXC, 1'b0, none});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur = 0;
        foreach (rows[r])
        begin
            if (rows[r].seg != cur)
            begin
                cur = rows[r].seg;
                one_seg = seg_set[cur];
                load_segment(one_seg);
            end
            send_point(rows[r].x, rows[r].y, rows[r].z, 0, rows[r].typed, rows[r].want);
        end

        random_phase(33, 360);
        random_phase(75, 360);
        random_phase(0, 360);

        start <= 1'b0;
        @(posedge clk);
        while (pending_near.size() != 0)
            @(posedge clk);
        repeat (TOTAL_LAT + 10) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
